>>> rtl/ascf_pkg.sv
`default_nettype none
package ascf_pkg;

    // Twenty decimal digits cover the unsigned 64-bit maximum.
    localparam int NUM_CELLS  = 20;
    localparam int HEX_CELLS  = 16;
    localparam int DIGIT_W    = 4;
    localparam int VALUE_W    = 64;
    localparam int HALF_W     = 32;
    localparam int CHAR_W     = 7;
    localparam int FUNC_W     = 3;
    localparam int REMAIN_W   = $clog2(NUM_CELLS + 1);
    localparam int BITCNT_W   = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h57;  // 'a' - 10
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    typedef enum logic [FUNC_W-1:0] {
        FMT_S32 = 3'd0,
        FMT_U32 = 3'd1,
        FMT_H32 = 3'd2,
        FMT_S64 = 3'd3,
        FMT_U64 = 3'd4,
        FMT_H64 = 3'd5
    } fmt_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_DABBLE,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_MINUS,
        ST_SKIP,
        ST_EMIT
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10)
        begin
            return CHAR_ZERO + ext;
        end
        return CHAR_ALPHA + ext;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ascf_operand_if.sv
`default_nettype none
interface ascf_operand_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [63:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface
`default_nettype wire

>>> rtl/ascf_char_if.sv
`default_nettype none
interface ascf_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

>>> rtl/ascf_cell.sv
`default_nettype none
module ascf_cell (
    input  logic                                clk,
    input  ascf_pkg::cell_op_t                  op,
    input  logic [ascf_pkg::DIGIT_W-1:0]        load_digit,
    input  logic                                shift_in_bit,
    input  logic [ascf_pkg::DIGIT_W-1:0]        shift_in_digit,
    output logic                                carry,
    output logic [ascf_pkg::DIGIT_W-1:0]        digit
);
    import ascf_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // Add three before the shift so the digit carries at ten.
    assign adj   = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry = adj[DIGIT_W-1];
    assign digit = digit_reg;

    always_comb
    begin
        case (op)
            CELL_LOAD:   digit_next = load_digit;
            CELL_DABBLE: digit_next = {adj[DIGIT_W-2:0], shift_in_bit};
            CELL_SHIFT:  digit_next = shift_in_digit;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule
`default_nettype wire

>>> rtl/integer_to_ascii_formatter_core.sv
`default_nettype none
// The operand is taken in the idle state; 64-bit and 32-bit decimal operands then pass
// bit-serial shift-and-add through the digit cells, while hex operands load straight into
// them. A minus sign follows for negative values, then up to 19 leading zeros are dropped
// and one character per cycle is sent while the receiver is ready. A new operand is taken
// only in the idle state, after the last character has been loaded for output.
// Reset: asynchronous, clears the sequencer and the output valid; digit cells are not reset.
module integer_to_ascii_formatter_core (
    input  logic           clk,
    input  logic           rst_n,
    ascf_operand_if.sink   operand,
    ascf_char_if.source    chars
);
    import ascf_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [VALUE_W-1:0]  mag_reg;
    logic [VALUE_W-1:0]  mag_next;
    logic [BITCNT_W-1:0] bit_cnt_reg;
    logic [BITCNT_W-1:0] bit_cnt_next;
    logic [REMAIN_W-1:0] remain_reg;
    logic [REMAIN_W-1:0] remain_next;
    logic                neg_reg;
    logic                neg_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg;
    logic [CHAR_W-1:0]   out_char_next;
    logic                out_last_reg;
    logic                out_last_next;

    logic                accept;
    logic                fmt_ok;
    logic                fmt_hex;
    logic                fmt_64;
    logic                fmt_signed;
    logic                in_neg;
    logic [HALF_W-1:0]   lo;
    logic [HALF_W-1:0]   mag32;
    logic [VALUE_W-1:0]  mag64;
    logic [VALUE_W-1:0]  hex_src;

    logic                out_free;
    logic                out_load;
    logic [CHAR_W-1:0]   out_load_char;
    logic                out_load_last;
    cell_op_t            cell_op;
    logic                top_zero;

    logic [DIGIT_W-1:0]  load_digit [NUM_CELLS];
    logic [DIGIT_W-1:0]  digit      [NUM_CELLS];
    logic                carry      [NUM_CELLS];

    // Operand decode
    always_comb
    begin
        fmt_ok     = 1'b1;
        fmt_hex    = 1'b0;
        fmt_64     = 1'b0;
        fmt_signed = 1'b0;
        case (fmt_t'(operand.func))
            FMT_S32: fmt_signed = 1'b1;
            FMT_U32: fmt_signed = 1'b0;
            FMT_H32: fmt_hex    = 1'b1;
            FMT_S64:
            begin
                fmt_signed = 1'b1;
                fmt_64     = 1'b1;
            end
            FMT_U64: fmt_64     = 1'b1;
            FMT_H64:
            begin
                fmt_hex = 1'b1;
                fmt_64  = 1'b1;
            end
            default: fmt_ok     = 1'b0;
        endcase
    end

    assign lo      = operand.value[HALF_W-1:0];
    assign in_neg  = fmt_signed & (fmt_64 ? operand.value[VALUE_W-1] : lo[HALF_W-1]);
    assign mag32   = in_neg ? (~lo + 1'b1) : lo;
    assign mag64   = in_neg ? (~operand.value + 1'b1) : operand.value;
    assign hex_src = fmt_64 ? operand.value : {{(VALUE_W-HALF_W){1'b0}}, lo};
    assign accept  = operand.valid & operand.ready;

    // Hex operands load straight into the cells, one nibble each.
    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_load
            if (gi < HEX_CELLS)
            begin : g_nib
                assign load_digit[gi] = fmt_hex ? hex_src[gi*DIGIT_W +: DIGIT_W] : '0;
            end
            else
            begin : g_zero
                assign load_digit[gi] = '0;
            end
        end
    endgenerate

    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                ascf_cell u_cell (
                    .clk            (clk),
                    .op             (cell_op),
                    .load_digit     (load_digit[gi]),
                    .shift_in_bit   (mag_reg[VALUE_W-1]),
                    .shift_in_digit ('0),
                    .carry          (carry[gi]),
                    .digit          (digit[gi])
                );
            end
            else
            begin : g_rest
                ascf_cell u_cell (
                    .clk            (clk),
                    .op             (cell_op),
                    .load_digit     (load_digit[gi]),
                    .shift_in_bit   (carry[gi-1]),
                    .shift_in_digit (digit[gi-1]),
                    .carry          (carry[gi]),
                    .digit          (digit[gi])
                );
            end
        end
    endgenerate

    assign top_zero = (digit[NUM_CELLS-1] == '0);
    assign out_free = ~out_valid_reg | chars.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && fmt_ok)
                begin
                    state_next = fmt_hex ? ST_SKIP : ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = neg_reg ? ST_MINUS : ST_SKIP;
                end
            end
            ST_MINUS:
            begin
                if (out_free)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!top_zero || remain_reg == REMAIN_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && remain_reg == REMAIN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        operand.ready = 1'b0;
        cell_op       = CELL_HOLD;
        out_load      = 1'b0;
        out_load_char = digit_to_ascii(digit[NUM_CELLS-1]);
        out_load_last = 1'b0;
        mag_next      = mag_reg;
        bit_cnt_next  = bit_cnt_reg;
        remain_next   = remain_reg;
        neg_next      = neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                operand.ready = 1'b1;
                if (accept)
                begin
                    cell_op      = CELL_LOAD;
                    neg_next     = in_neg;
                    remain_next  = REMAIN_W'(NUM_CELLS);
                    // 32-bit magnitudes sit in the upper half so the MSB shifts out first.
                    mag_next     = fmt_64 ? mag64 : {mag32, {HALF_W{1'b0}}};
                    bit_cnt_next = fmt_64 ? BITCNT_W'(VALUE_W - 1) : BITCNT_W'(HALF_W - 1);
                end
            end
            ST_CONV:
            begin
                cell_op      = CELL_DABBLE;
                mag_next     = mag_reg << 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
            end
            ST_MINUS:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_load_char = CHAR_MINUS;
                end
            end
            ST_SKIP:
            begin
                // Drop a leading zero, but keep the last digit.
                if (top_zero && remain_reg != REMAIN_W'(1))
                begin
                    cell_op     = CELL_SHIFT;
                    remain_next = remain_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_load_last = (remain_reg == REMAIN_W'(1));
                    cell_op       = CELL_SHIFT;
                    remain_next   = remain_reg - 1'b1;
                end
            end
            default: cell_op = CELL_HOLD;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = out_load_char;
            out_last_next  = out_load_last;
        end
        else if (chars.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign chars.valid     = out_valid_reg;
    assign chars.char_code = out_char_reg;
    assign chars.last_char = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bit_cnt_reg  <= bit_cnt_next;
        remain_reg   <= remain_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule
`default_nettype wire

>>> test/tb_integer_to_ascii_formatter_core.sv
`default_nettype none
module tb_integer_to_ascii_formatter_core;
    import ascf_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 96;
    localparam int DRAIN_CYCLES   = 150;
    localparam int HOLDOFF_AFTER  = 40;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int TIMEOUT_CYCLES = 300000;
    localparam int MAX_REPORTS    = 10;

    // Selector codes the block has no format for.
    localparam logic [FUNC_W-1:0] FMT_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FMT_RSVD7 = 3'd7;

    typedef struct
    {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        int unsigned        gap;
    } operand_item_t;

    typedef struct packed
    {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic clk;
    logic rst_n;

    ascf_operand_if operand_bus ();
    ascf_char_if    char_bus ();

    integer_to_ascii_formatter_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_bus),
        .chars   (char_bus)
    );

    operand_item_t pending_operands[$];
    text_char_t    expected_text[$];

    int unsigned gap_count;
    int unsigned operands_taken;
    int unsigned chars_seen;
    int unsigned rx_stall;
    int unsigned holdoff_left;
    logic        holdoff_fired;
    int unsigned mismatches;
    text_char_t  head_char;

    // Append the characters that one operand should produce.
    task automatic predict_text(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        logic [VALUE_W-1:0] radix;
        logic [VALUE_W-1:0] rem;
        logic               negative;
        logic [CHAR_W-1:0]  digits[$];
        text_char_t         entry;
        begin
            negative  = 1'b0;
            radix     = 64'd10;
            magnitude = value;
            case (func)
                FMT_S32:
                begin
                    negative  = value[31];
                    magnitude = negative ? {32'd0, -value[31:0]} : {32'd0, value[31:0]};
                end
                FMT_U32:
                begin
                    magnitude = {32'd0, value[31:0]};
                end
                FMT_H32:
                begin
                    magnitude = {32'd0, value[31:0]};
                    radix     = 64'd16;
                end
                FMT_S64:
                begin
                    negative  = value[63];
                    magnitude = negative ? -value : value;
                end
                FMT_U64:
                begin
                    magnitude = value;
                end
                FMT_H64:
                begin
                    radix = 64'd16;
                end
                default:
                begin
                    return;
                end
            endcase
            do
            begin
                rem = magnitude % radix;
                digits.push_front((rem < 64'd10) ? CHAR_ZERO + {3'b000, rem[3:0]}
                                                 : CHAR_ALPHA + {3'b000, rem[3:0]});
                magnitude = magnitude / radix;
            end
            while (magnitude != 64'd0);
            if (negative)
            begin
                entry.code = CHAR_MINUS;
                entry.last = 1'b0;
                expected_text.push_back(entry);
            end
            foreach (digits[i])
            begin
                entry.code = digits[i];
                entry.last = (i == digits.size() - 1);
                expected_text.push_back(entry);
            end
        end
    endtask

    task automatic queue_operand(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
                                 input int unsigned gap);
        operand_item_t item;
        begin
            item.func  = func;
            item.value = value;
            item.gap   = gap;
            pending_operands.push_back(item);
        end
    endtask

    // Spread magnitudes over all lengths: full width, short, and small negatives.
    function automatic logic [VALUE_W-1:0] random_operand();
        logic [VALUE_W-1:0] raw;
        int unsigned        shift;
        begin
            raw   = {$urandom, $urandom};
            shift = $urandom_range(0, 63);
            case ($urandom_range(0, 3))
                0: return raw;
                1: return raw >> shift;
                2: return ~(raw >> shift);
                default: return {raw[63:32], ~(raw[31:0] >> shift[4:0])};
            endcase
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        rst_n                = 1'b0;
        operand_bus.valid    = 1'b0;
        operand_bus.func     = FMT_S32;
        operand_bus.value    = '0;
        char_bus.ready       = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

    // Sender: present queued operands, each after its own idle gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_bus.valid <= 1'b0;
            operand_bus.func  <= FMT_S32;
            operand_bus.value <= '0;
            gap_count         = 0;
            operands_taken    <= 0;
        end
        else
        begin
            if (operand_bus.valid && operand_bus.ready)
            begin
                predict_text(operand_bus.func, operand_bus.value);
                operands_taken <= operands_taken + 1;
            end
            if (!operand_bus.valid || operand_bus.ready)
            begin
                if (pending_operands.size() != 0 && gap_count >= pending_operands[0].gap)
                begin
                    operand_bus.valid <= 1'b1;
                    operand_bus.func  <= pending_operands[0].func;
                    operand_bus.value <= pending_operands[0].value;
                    void'(pending_operands.pop_front());
                    gap_count = 0;
                end
                else
                begin
                    operand_bus.valid <= 1'b0;
                    if (pending_operands.size() != 0)
                    begin
                        gap_count = gap_count + 1;
                    end
                end
            end
        end
    end

    // One long receiver hold-off once the stream is well under way.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left  <= 0;
            holdoff_fired <= 1'b0;
        end
        else if (!holdoff_fired && operands_taken >= HOLDOFF_AFTER)
        begin
            holdoff_left  <= HOLDOFF_CYCLES;
            holdoff_fired <= 1'b1;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    // Receiver: check each character transaction against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_bus.ready <= 1'b0;
            rx_stall       = 0;
            chars_seen     = 0;
            mismatches     = 0;
        end
        else
        begin
            if (char_bus.valid && char_bus.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("unexpected char %h last %0b",
                                 char_bus.char_code, char_bus.last_char);
                    end
                end
                else
                begin
                    head_char = expected_text.pop_front();
                    if (char_bus.char_code !== head_char.code || char_bus.last_char !== head_char.last)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("char mismatch: expected %h last %0b, got %h last %0b",
                                     head_char.code, head_char.last,
                                     char_bus.char_code, char_bus.last_char);
                        end
                    end
                end
                chars_seen = chars_seen + 1;
                // Stay always-ready over one window of every 64 characters.
                rx_stall = (chars_seen[5:4] == 2'b00) ? 0 : $urandom_range(0, 5);
            end
            else if (rx_stall != 0)
            begin
                rx_stall = rx_stall - 1;
            end
            char_bus.ready <= (holdoff_left == 0) && (rx_stall == 0);
        end
    end

    initial
    begin
        int unsigned counted;
        logic        calm;
        logic [FUNC_W-1:0] func;

        // Extremes, every format, ignored upper bits and unused selectors.
        queue_operand(FMT_S32, 64'h0000_0000_0000_0000, 0);
        queue_operand(FMT_S32, 64'h0000_0000_7fff_ffff, 1);
        queue_operand(FMT_S32, 64'h0000_0000_8000_0000, 0);
        queue_operand(FMT_S32, 64'hffff_ffff_ffff_ffff, 3);
        queue_operand(FMT_S32, 64'hdead_beef_0000_0005, 0);
        queue_operand(FMT_U32, 64'h0000_0000_0000_0000, 2);
        queue_operand(FMT_U32, 64'h0000_0000_ffff_ffff, 0);
        queue_operand(FMT_U32, 64'hffff_ffff_0000_0009, 5);
        queue_operand(FMT_H32, 64'h0000_0000_0000_0000, 0);
        queue_operand(FMT_H32, 64'h0000_0000_ffff_ffff, 0);
        queue_operand(FMT_H32, 64'h1234_5678_0000_abcd, 4);
        queue_operand(FMT_S64, 64'h0000_0000_0000_0000, 0);
        queue_operand(FMT_S64, 64'h7fff_ffff_ffff_ffff, 1);
        queue_operand(FMT_S64, 64'h8000_0000_0000_0000, 0);
        queue_operand(FMT_S64, 64'hffff_ffff_ffff_ffff, 0);
        queue_operand(FMT_U64, 64'h0000_0000_0000_0000, 2);
        queue_operand(FMT_U64, 64'hffff_ffff_ffff_ffff, 0);
        queue_operand(FMT_U64, 64'h0000_0000_3b9a_ca00, 0);
        queue_operand(FMT_H64, 64'h0000_0000_0000_0000, 3);
        queue_operand(FMT_H64, 64'hffff_ffff_ffff_ffff, 0);
        queue_operand(FMT_H64, 64'h0123_4567_89ab_cdef, 0);
        queue_operand(FMT_RSVD6, 64'hffff_ffff_ffff_ffff, 0);
        queue_operand(FMT_RSVD7, 64'h0000_0000_0000_0001, 1);
        queue_operand(FMT_U32, 64'h0000_0000_0000_0007, 0);

        counted = 0;
        calm    = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted % 16 == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 15) == 0)
            begin
                func = $urandom_range(0, 1) ? FMT_RSVD6 : FMT_RSVD7;
            end
            else
            begin
                func    = FUNC_W'($urandom_range(FMT_S32, FMT_H64));
                counted = counted + 1;
            end
            queue_operand(func, random_operand(), calm ? 0 : $urandom_range(0, 5));
        end

        wait (rst_n);
        while (pending_operands.size() != 0 || operand_bus.valid)
        begin
            @(posedge clk);
        end
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_text.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> integer_to_ascii_formatter_core.f
rtl/ascf_pkg.sv
rtl/ascf_operand_if.sv
rtl/ascf_char_if.sv
rtl/ascf_cell.sv
rtl/integer_to_ascii_formatter_core.sv
test/tb_integer_to_ascii_formatter_core.sv
